// ===== rtl/nru_pkg.sv =====
// ----------------------------------------------------------------------------
// NRU block cache table package
// Shared widths, controller types and selection helpers for the NRU table.
// ----------------------------------------------------------------------------
`default_nettype none

package nru_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// Field widths.
	localparam int FILE_W  = 8;
	localparam int BLOCK_W = 32;
	localparam int SLOT_W  = 6;
	localparam int CFG_W   = 7;
	localparam int TAG_W   = FILE_W + BLOCK_W;
	localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// Stream packing.
	localparam int S_TDATA_W = ((TAG_W + 7) / 8) * 8;
	localparam int RES_W     = 1 + SLOT_W + 1 + 1 + FILE_W + BLOCK_W;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Reset value of the active entry limit.
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

	// NRU class codes: accessed bit above dirty bit.
	localparam logic [1:0] CLS_CLEAN      = 2'd0;
	localparam logic [1:0] CLS_DIRTY      = 2'd1;
	localparam logic [1:0] CLS_ACC_CLEAN  = 2'd2;
	localparam logic [1:0] CLS_ACC_DIRTY  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SEL,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic capture;
		logic look;
		logic select;
		logic commit;
	} ctrl_cmd_t;

	// Lowest set bit of a table-wide vector; zero when none is set.
	function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/nru_ram.sv =====
// ----------------------------------------------------------------------------
// NRU generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module nru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/nru_ctrl.sv =====
// ----------------------------------------------------------------------------
// NRU table controller
// Sequences lookup, victim selection and table update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module nru_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output nru_pkg::ctrl_cmd_t      cmd,
	output nru_pkg::state_t         state
);
	import nru_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: state_d = ST_SEL;
			ST_SEL:  state_d = ST_UPD;
			ST_UPD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_LOOK: cmd.look   = 1'b1;
			ST_SEL:  cmd.select = 1'b1;
			ST_UPD:  cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign state    = state_q;

endmodule

`default_nettype wire

// ===== rtl/nru_dpath.sv =====
// ----------------------------------------------------------------------------
// NRU table datapath
// Tag registers, parallel compare, class selection, victim RAM and result.
// ----------------------------------------------------------------------------
`default_nettype none

module nru_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire nru_pkg::ctrl_cmd_t            cmd,
	input  wire logic                          cfg_we,
	input  wire logic [nru_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_req_type,
	input  wire logic [nru_pkg::FILE_W-1:0]    in_file_id,
	input  wire logic [nru_pkg::BLOCK_W-1:0]   in_block,
	output logic                               res_hit,
	output logic      [nru_pkg::SLOT_W-1:0]    res_slot,
	output logic                               res_evicted,
	output logic                               res_writeback,
	output logic      [nru_pkg::FILE_W-1:0]    res_victim_file,
	output logic      [nru_pkg::BLOCK_W-1:0]   res_victim_block
);
	import nru_pkg::*;

	// Entry state. Tags are compared in place; a copy in RAM serves victim readout.
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] acc_q;
	logic [TABLE_ENTRIES-1:0] dirty_q;
	logic [FILE_W-1:0]        file_q  [TABLE_ENTRIES];
	logic [BLOCK_W-1:0]       block_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]         count_q;
	logic [CFG_W-1:0]         limit_q;

	// Captured request.
	logic               wr_q;
	logic [FILE_W-1:0]  fid_q;
	logic [BLOCK_W-1:0] bn_q;

	// Pipeline of the item.
	logic [TABLE_ENTRIES-1:0] match_s1;
	logic                     hit_s2;
	logic [IDX_W-1:0]         hit_idx_s2;
	logic                     evict_s2;
	logic [IDX_W-1:0]         victim_s2;
	logic [1:0]               cls_s2;

	// Result register.
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               evicted_q;
	logic               wb_q;
	logic [FILE_W-1:0]  vfile_q;
	logic [BLOCK_W-1:0] vblock_q;

	logic [TABLE_ENTRIES-1:0] match;
	logic [TABLE_ENTRIES-1:0] m_clean, m_dirty, m_acc_clean, m_acc_dirty;
	logic [TABLE_ENTRIES-1:0] cls_mask;
	logic [1:0]               cls_sel;
	logic [IDX_W-1:0]         victim_sel;
	logic [CMP_W-1:0]         eff_limit;
	logic                     full;
	logic [TABLE_ENTRIES-1:0] free_mask;
	logic [IDX_W-1:0]         free_idx;
	logic [TAG_W-1:0]         ram_rdata;

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = valid_q[i] && (file_q[i] == fid_q) && (block_q[i] == bn_q);
		end
	end

	assign m_clean     = valid_q & ~acc_q & ~dirty_q;
	assign m_dirty     = valid_q & ~acc_q &  dirty_q;
	assign m_acc_clean = valid_q &  acc_q & ~dirty_q;
	assign m_acc_dirty = valid_q &  acc_q &  dirty_q;

	always_comb begin
		if (|m_clean) begin
			cls_sel  = CLS_CLEAN;
			cls_mask = m_clean;
		end else if (|m_dirty) begin
			cls_sel  = CLS_DIRTY;
			cls_mask = m_dirty;
		end else if (|m_acc_clean) begin
			cls_sel  = CLS_ACC_CLEAN;
			cls_mask = m_acc_clean;
		end else begin
			cls_sel  = CLS_ACC_DIRTY;
			cls_mask = m_acc_dirty;
		end
	end

	assign victim_sel = first_set(cls_mask);

	// A zero limit acts as one; a limit above the table acts as the table size.
	always_comb begin
		if (limit_q == '0) begin
			eff_limit = CMP_W'(1);
		end else if (CMP_W'(limit_q) > CMP_W'(TABLE_ENTRIES)) begin
			eff_limit = CMP_W'(TABLE_ENTRIES);
		end else begin
			eff_limit = CMP_W'(limit_q);
		end
	end

	assign full = CMP_W'(count_q) >= eff_limit;

	// The victim slot counts as free when it is evicted by this item.
	always_comb begin
		free_mask = ~valid_q;
		if (evict_s2) begin
			free_mask[victim_s2] = 1'b1;
		end
	end

	assign free_idx = first_set(free_mask);

	nru_ram #(
		.WIDTH(TAG_W),
		.DEPTH(TABLE_ENTRIES)
	) u_tag_ram (
		.clk  (clk),
		.we   (cmd.commit && !hit_s2),
		.waddr(free_idx),
		.wdata({fid_q, bn_q}),
		.re   (cmd.select),
		.raddr(victim_sel),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acc_q   <= '0;
			dirty_q <= '0;
			count_q <= '0;
			limit_q <= CFG_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (hit_s2) begin
					acc_q[hit_idx_s2] <= 1'b1;
					if (wr_q) begin
						dirty_q[hit_idx_s2] <= 1'b1;
					end
				end else begin
					valid_q[free_idx] <= 1'b1;
					acc_q[free_idx]   <= 1'b0;
					dirty_q[free_idx] <= wr_q;
					if (evict_s2 && (victim_s2 != free_idx)) begin
						valid_q[victim_s2] <= 1'b0;
						acc_q[victim_s2]   <= 1'b0;
						dirty_q[victim_s2] <= 1'b0;
					end
					if (!evict_s2) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wr_q  <= in_req_type;
			fid_q <= in_file_id;
			bn_q  <= in_block;
		end
		if (cmd.look) begin
			match_s1 <= match;
		end
		if (cmd.select) begin
			hit_s2     <= |match_s1;
			hit_idx_s2 <= first_set(match_s1);
			evict_s2   <= !(|match_s1) && full;
			victim_s2  <= victim_sel;
			cls_s2     <= cls_sel;
		end
		if (cmd.commit) begin
			if (!hit_s2) begin
				file_q[free_idx]  <= fid_q;
				block_q[free_idx] <= bn_q;
			end
			hit_q     <= hit_s2;
			slot_q    <= hit_s2 ? SLOT_W'(hit_idx_s2) : SLOT_W'(free_idx);
			evicted_q <= evict_s2;
			wb_q      <= evict_s2 && cls_s2[0];
			vfile_q   <= evict_s2 ? ram_rdata[TAG_W-1 -: FILE_W] : '0;
			vblock_q  <= evict_s2 ? ram_rdata[BLOCK_W-1:0] : '0;
		end
	end

	assign res_hit          = hit_q;
	assign res_slot         = slot_q;
	assign res_evicted      = evicted_q;
	assign res_writeback    = wb_q;
	assign res_victim_file  = vfile_q;
	assign res_victim_block = vblock_q;

endmodule

`default_nettype wire

// ===== rtl/nru_block_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// NRU block cache table
// Tag and state table of a block cache with not-recently-used replacement.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one access: s_tuser carries the request
// type (0 read, 1 write) and s_tdata carries the file id and block number.
// Each accepted item yields exactly one item on the master stream reporting
// hit or miss, the slot now holding the block and, on an eviction, the victim
// tags and whether the victim was dirty and needs a writeback.
// The items are handled one at a time by a four-state controller: capture,
// parallel tag compare, class priority selection with the victim tag read
// from RAM, then the table update that loads the result register. A new
// item can be taken only once the update of the previous one is done. The
// chain of compare, selection and registered RAM read sets that pace.
// If the receiver stalls, a finished result waits in the output register;
// the next item is still accepted and worked on, and only its update step
// waits until the output register is free.
// Reset empties the table at once (valid, accessed and dirty bits clear) and
// sets the active entry limit to 64. The user must write the limit (cfg_we,
// cfg_wdata) only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module nru_block_cache_table_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Slave stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// file_id [7:0], block_idx [39:8]
	input  wire logic [nru_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type [0]
	input  wire logic                            s_tuser,
	// Master stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// hit [0], slot [6:1], evicted [7], writeback [8], victim_file_id [16:9],
	// victim_block [48:17], zero fill above
	output logic      [nru_pkg::M_TDATA_W-1:0]   m_tdata,
	// Configuration: active_entries.
	input  wire logic                            cfg_we,
	input  wire logic [nru_pkg::CFG_W-1:0]       cfg_wdata
);
	import nru_pkg::*;

	ctrl_cmd_t          cmd;
	state_t             state;
	logic               res_hit;
	logic [SLOT_W-1:0]  res_slot;
	logic               res_evicted;
	logic               res_writeback;
	logic [FILE_W-1:0]  res_victim_file;
	logic [BLOCK_W-1:0] res_victim_block;

	// The controller only sequences; all table state lives in the datapath.
	nru_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.state   (state)
	);

	nru_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_req_type     (s_tuser),
		.in_file_id      (s_tdata[FILE_W-1:0]),
		.in_block        (s_tdata[TAG_W-1:FILE_W]),
		.res_hit         (res_hit),
		.res_slot        (res_slot),
		.res_evicted     (res_evicted),
		.res_writeback   (res_writeback),
		.res_victim_file (res_victim_file),
		.res_victim_block(res_victim_block)
	);

	// Result fields packed from the lowest bit up, zero filled to whole bytes.
	assign m_tdata = M_TDATA_W'({res_victim_block, res_victim_file, res_writeback,
		res_evicted, res_slot, res_hit});

	// After an item is taken, the block is busy until its update is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while the previous one is in flight");

	// A hit never reports an eviction or victim tags.
	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_hit |-> !res_evicted && !res_writeback
			&& (res_victim_file == '0) && (res_victim_block == '0))
		else $error("hit result carries victim information");

	// A writeback is only reported for an evicted victim.
	a_wb_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_writeback |-> res_evicted)
		else $error("writeback without eviction");

	// A new result only comes out of the update step.
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state == ST_UPD))
		else $error("result presented without a table update");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the NRU block cache table
// Drives cache accesses on the slave stream and checks every result item on
// the master stream against a behavioral table copy or a hand-written value.
// ----------------------------------------------------------------------------
// The run starts with a short directed plan. It covers the field extremes,
// hits on reads and writes, eviction from the clean and dirty classes, a
// dirty victim, a zero limit, a limit above the table size, and a limit
// lowered below the current occupancy. Random phases follow, each under its
// own active entry limit, with both stream sides idling at random.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nru_pkg::*;

	// Request type codes carried on s_tuser.
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Class rank above every real NRU class, used as the "none yet" marker.
	localparam logic [2:0] NO_CLASS = 3'd4;

	// One access as packed on s_tdata: block number above file id.
	typedef struct packed {
		logic               wr;
		logic [BLOCK_W-1:0] blk;
		logic [FILE_W-1:0]  fid;
	} access_t;

	// One result, laid out exactly like m_tdata from the top bit down so that
	// the low RES_W bits of the bus can be cast straight into it.
	typedef struct packed {
		logic [BLOCK_W-1:0] victim_block;
		logic [FILE_W-1:0]  victim_file;
		logic               writeback;
		logic               evicted;
		logic [SLOT_W-1:0]  slot;
		logic               hit;
	} outcome_t;

	typedef enum logic {ROW_ACCESS, ROW_LIMIT} row_kind_t;

	// One row of the directed plan: either a limit write or an access, with
	// an optional hand-written expectation.
	typedef struct packed {
		row_kind_t         kind;
		logic [CFG_W-1:0]  limit;
		access_t           acc;
		logic              typed;
		outcome_t          want;
	} plan_row_t;

	// One random phase: the limit in force, the number of accesses and the
	// span of block numbers they are drawn from (small spans give hits).
	typedef struct packed {
		logic [CFG_W-1:0] limit;
		int unsigned      items;
		int unsigned      span;
	} phase_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   cfg_we;
	logic [CFG_W-1:0]       cfg_wdata;

	nru_block_cache_table_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		// file_id [7:0], block_idx [39:8]
		.s_tdata   (s_tdata),
		// req_type [0]
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		// hit [0], slot [6:1], evicted [7], writeback [8], victim_file_id [16:9],
		// victim_block [48:17], zero fill above
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Cycle counter that opens a window in which neither side idles, so the
	// block also runs at its full rate for a while.
	int unsigned cycle_count = 0;
	logic        steady;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	assign steady = (cycle_count >= 900) && (cycle_count < 1500);

	// ------------------------------------------------------------------------
	// Behavioral copy of the table and its limit register.
	// ------------------------------------------------------------------------
	logic               tag_valid [TABLE_ENTRIES];
	logic [FILE_W-1:0]  tag_file  [TABLE_ENTRIES];
	logic [BLOCK_W-1:0] tag_block [TABLE_ENTRIES];
	logic               used_bit  [TABLE_ENTRIES];
	logic               dirty_bit [TABLE_ENTRIES];
	logic [CFG_W-1:0]   limit_reg;

	// Expected results in acceptance order, oldest at the front.
	outcome_t pending_outcomes [$];

	int fail_count    = 0;
	int access_count  = 0;
	int hit_count     = 0;
	int evict_count   = 0;
	int wb_count      = 0;
	int setting_count = 0;

	// Looks the access up, evicts on a miss if the table is at its limit,
	// installs the block, and returns the result the block should report.
	function automatic outcome_t lookup_and_replace(input access_t a);
		outcome_t   o;
		int         eff_limit;
		int         occupied;
		int         victim;
		int         free_idx;
		logic [2:0] best;
		logic [2:0] rank;

		o = '0;
		eff_limit = (limit_reg == 0) ? 1 :
			(int'(limit_reg) > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(limit_reg);

		// A hit only updates the status bits of the matching entry.
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tag_valid[i] && tag_file[i] == a.fid && tag_block[i] == a.blk) begin
				used_bit[i] = 1'b1;
				if (a.wr == REQ_WRITE) begin
					dirty_bit[i] = 1'b1;
				end
				o.hit  = 1'b1;
				o.slot = SLOT_W'(i);
				return o;
			end
		end

		occupied = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tag_valid[i]) begin
				occupied++;
			end
		end

		// At or above the limit exactly one victim goes, taken from the whole
		// table: lowest class first, lowest slot within the class.
		if (occupied >= eff_limit) begin
			best   = NO_CLASS;
			victim = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				rank = {1'b0, used_bit[i], dirty_bit[i]};
				if (tag_valid[i] && rank < best) begin
					best   = rank;
					victim = i;
				end
			end
			if (victim >= 0) begin
				o.evicted      = 1'b1;
				o.writeback    = dirty_bit[victim];
				o.victim_file  = tag_file[victim];
				o.victim_block = tag_block[victim];
				tag_valid[victim] = 1'b0;
				used_bit[victim]  = 1'b0;
				dirty_bit[victim] = 1'b0;
			end
		end

		free_idx = 0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!tag_valid[i]) begin
				free_idx = i;
			end
		end

		tag_valid[free_idx] = 1'b1;
		tag_file[free_idx]  = a.fid;
		tag_block[free_idx] = a.blk;
		used_bit[free_idx]  = 1'b0;
		dirty_bit[free_idx] = a.wr;
		o.slot = SLOT_W'(free_idx);
		return o;
	endfunction

	// ------------------------------------------------------------------------
	// Plan helpers.
	// ------------------------------------------------------------------------
	function automatic plan_row_t access_row(input logic wr, input logic [FILE_W-1:0] fid,
			input logic [BLOCK_W-1:0] blk);
		plan_row_t r;
		r = '0;
		r.kind = ROW_ACCESS;
		r.acc  = '{wr: wr, blk: blk, fid: fid};
		return r;
	endfunction

	function automatic plan_row_t checked_row(input logic wr, input logic [FILE_W-1:0] fid,
			input logic [BLOCK_W-1:0] blk, input outcome_t want);
		plan_row_t r;
		r = access_row(wr, fid, blk);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic plan_row_t limit_row(input logic [CFG_W-1:0] v);
		plan_row_t r;
		r = '0;
		r.kind  = ROW_LIMIT;
		r.limit = v;
		return r;
	endfunction

	function automatic outcome_t outcome(input logic hit, input int slot, input logic ev,
			input logic wb, input logic [FILE_W-1:0] vf, input logic [BLOCK_W-1:0] vb);
		outcome_t o;
		o.hit          = hit;
		o.slot         = SLOT_W'(slot);
		o.evicted      = ev;
		o.writeback    = wb;
		o.victim_file  = vf;
		o.victim_block = vb;
		return o;
	endfunction

	// Random access: mostly a small pool of tags so that hits and every
	// replacement class show up, sometimes fully random tags so that every
	// bit of the fields toggles.
	function automatic access_t draw_access(input int unsigned span);
		access_t a;
		a.wr = ($urandom_range(0, 99) < 40) ? REQ_WRITE : REQ_READ;
		if ($urandom_range(0, 99) < 15) begin
			a.fid = FILE_W'($urandom);
			a.blk = $urandom;
		end else begin
			a.fid = $urandom_range(0, 1) ? 8'hC3 : 8'h3C;
			a.blk = BLOCK_W'($urandom_range(0, span));
		end
		return a;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus side.
	// ------------------------------------------------------------------------

	// Offers one access and waits for the handshake. The valid stays high on
	// return so that a following access can go out back to back; the idle
	// loop lowers it when the sender pauses.
	task automatic offer_access(input access_t a, input logic typed, input outcome_t typed_want);
		outcome_t predicted;
		while (!steady && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= a.wr;
		s_tdata  <= S_TDATA_W'({a.blk, a.fid});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		// The block handles items one at a time, so the prediction runs here,
		// in acceptance order.
		predicted = lookup_and_replace(a);
		pending_outcomes = {pending_outcomes, (typed ? typed_want : predicted)};
		access_count++;
		hit_count   += predicted.hit;
		evict_count += predicted.evicted;
		wb_count    += predicted.writeback;
	endtask

	// Writes the limit once the block has returned every result. Each access
	// gives exactly one result, so an empty queue means the block is idle.
	task automatic apply_limit(input logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_reg = v;
		setting_count++;
	endtask

	plan_row_t directed_plan [$];

	// Appends one row at the end of the directed plan.
	function automatic void add_row(input plan_row_t r);
		directed_plan = {directed_plan, r};
	endfunction

	// Limits climb from zero while the table is nearly empty, since occupancy
	// never falls; the last phases go past the table size and then drop the
	// limit far below the occupancy reached, before raising it to 64 again.
	phase_t random_phases [9] = '{
		'{limit: 7'd0,   items: 30, span: 4},
		'{limit: 7'd2,   items: 30, span: 4},
		'{limit: 7'd4,   items: 40, span: 6},
		'{limit: 7'd8,   items: 40, span: 10},
		'{limit: 7'd16,  items: 50, span: 24},
		'{limit: 7'd64,  items: 80, span: 60},
		'{limit: 7'd127, items: 70, span: 120},
		'{limit: 7'd3,   items: 30, span: 40},
		'{limit: 7'd64,  items: 30, span: 40}
	};

	initial begin : run_plan
		int drain_cycles;

		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_READ;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;

		// The model table starts empty with the reset limit.
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tag_valid[i] = 1'b0;
			tag_file[i]  = '0;
			tag_block[i] = '0;
			used_bit[i]  = 1'b0;
			dirty_bit[i] = 1'b0;
		end
		limit_reg = CFG_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Under the reset limit: first miss, read hit, extreme tags with a
		// write hit, then a clean and a dirty entry that are never touched.
		add_row(checked_row(REQ_READ, 8'h00, 32'h0000_0000,
			outcome(1'b0, 0, 1'b0, 1'b0, 8'h00, 32'h0)));
		add_row(checked_row(REQ_READ, 8'h00, 32'h0000_0000,
			outcome(1'b1, 0, 1'b0, 1'b0, 8'h00, 32'h0)));
		add_row(checked_row(REQ_WRITE, 8'hFF, 32'hFFFF_FFFF,
			outcome(1'b0, 1, 1'b0, 1'b0, 8'h00, 32'h0)));
		add_row(checked_row(REQ_WRITE, 8'hFF, 32'hFFFF_FFFF,
			outcome(1'b1, 1, 1'b0, 1'b0, 8'h00, 32'h0)));
		add_row(access_row(REQ_READ, 8'h00, 32'h0000_0001));
		add_row(access_row(REQ_WRITE, 8'h01, 32'h0000_0000));
		// A zero limit acts as one and sits below the occupancy of four, so
		// each miss evicts from the lowest class, an untouched clean entry.
		add_row(limit_row(7'd0));
		add_row(checked_row(REQ_READ, 8'h02, 32'h0000_0002,
			outcome(1'b0, 2, 1'b1, 1'b0, 8'h00, 32'h1)));
		add_row(checked_row(REQ_READ, 8'h03, 32'h0000_0003,
			outcome(1'b0, 2, 1'b1, 1'b0, 8'h02, 32'h2)));
		// A limit above the table acts as the table size: misses just fill.
		add_row(limit_row(7'd127));
		add_row(access_row(REQ_READ, 8'h03, 32'h0000_0003));
		add_row(access_row(REQ_READ, 8'h04, 32'h0000_0004));
		// Limit of one: the clean victim goes first, then a dirty one that
		// needs a writeback.
		add_row(limit_row(7'd1));
		add_row(checked_row(REQ_WRITE, 8'h05, 32'h0000_0005,
			outcome(1'b0, 4, 1'b1, 1'b0, 8'h04, 32'h4)));
		add_row(checked_row(REQ_READ, 8'h06, 32'h0000_0006,
			outcome(1'b0, 3, 1'b1, 1'b1, 8'h01, 32'h0)));
		add_row(access_row(REQ_WRITE, 8'h06, 32'h0000_0006));
		add_row(access_row(REQ_READ, 8'h80, 32'h7FFF_FFFF));
		add_row(access_row(REQ_READ, 8'hFF, 32'h0000_0000));
		add_row(access_row(REQ_WRITE, 8'h00, 32'hFFFF_FFFF));
		add_row(access_row(REQ_READ, 8'hFF, 32'hFFFF_FFFF));

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_LIMIT) begin
				apply_limit(directed_plan[i].limit);
			end else begin
				offer_access(directed_plan[i].acc, directed_plan[i].typed,
					directed_plan[i].want);
			end
		end

		foreach (random_phases[p]) begin
			apply_limit(random_phases[p].limit);
			repeat (random_phases[p].items) begin
				offer_access(draw_access(random_phases[p].span), 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		// Let the last results come out, with a bound, then keep watching to
		// catch anything stray.
		drain_cycles = 0;
		while (pending_outcomes.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (8) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_outcomes.size());
			fail_count++;
		end

		$display("Run covered %0d accesses under %0d limit settings:", access_count,
			setting_count);
		$display("  %0d hits, %0d evictions, %0d dirty writebacks.", hit_count,
			evict_count, wb_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side.
	// ------------------------------------------------------------------------
	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Takes results with a random ready, and twice holds ready low for a long
	// stretch so that the output register fills and the block stops taking
	// new accesses while the sender keeps offering them.
	initial begin : take_results
		int       hold_left;
		int       seen;
		outcome_t got;
		outcome_t want;

		hold_left = 0;
		seen      = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = outcome_t'(m_tdata[RES_W-1:0]);
				if (pending_outcomes.size() == 0) begin
					$display("%0t: result with nothing expected, got 0x%0h", $time, got);
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("hit", 32'(want.hit), 32'(got.hit));
					compare_field("slot", 32'(want.slot), 32'(got.slot));
					compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
					compare_field("writeback", 32'(want.writeback), 32'(got.writeback));
					compare_field("victim_file_id", 32'(want.victim_file),
						32'(got.victim_file));
					compare_field("victim_block", want.victim_block, got.victim_block);
				end
				seen++;
				if (seen == 60 || seen == 250) begin
					hold_left = 80;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// Watchdog: a correct run needs well under a tenth of this time.
	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
